>>> hdl/mmbd_pkg.sv
package mmbd_pkg;

   // Address map
   localparam logic [15:0] ADDR_VRAM_BASE     = 16'h8000;
   localparam logic [15:0] ADDR_CART_RAM_BASE = 16'hA000;
   localparam logic [15:0] ADDR_WRAM_BASE     = 16'hC000;
   localparam logic [15:0] ADDR_OAM_BASE      = 16'hFE00;
   localparam logic [15:0] ADDR_UNUSABLE_BASE = 16'hFEA0;
   localparam logic [15:0] ADDR_IO_BASE       = 16'hFF00;
   localparam logic [15:0] ADDR_HRAM_BASE     = 16'hFF80;
   localparam logic [15:0] ADDR_IE            = 16'hFFFF;
   localparam logic [15:0] ADDR_JOYPAD        = 16'hFF00;
   localparam logic [15:0] ADDR_SERIAL_CTRL   = 16'hFF02;
   localparam logic [15:0] ADDR_TIMER_LO      = 16'hFF04;
   localparam logic [15:0] ADDR_TIMER_HI      = 16'hFF07;
   localparam logic [15:0] ADDR_IF            = 16'hFF0F;
   localparam logic [15:0] ADDR_AUDIO_LO      = 16'hFF10;
   localparam logic [15:0] ADDR_AUDIO_HI      = 16'hFF3F;
   localparam logic [15:0] ADDR_LCD_LO        = 16'hFF40;
   localparam logic [15:0] ADDR_LCD_HI        = 16'hFF4B;

   localparam logic [7:0] IF_RESET         = 8'hE1;
   localparam logic [7:0] IE_RESET         = 8'h00;
   localparam logic [7:0] IF_READ_SET      = 8'hE0;
   localparam logic [7:0] SERIAL_CTRL_MASK = 8'h7F;
   localparam logic [7:0] UNUSABLE_READ    = 8'hFF;

   localparam int WRAM_DEPTH  = 8192;
   localparam int WRAM_AW     = $clog2(WRAM_DEPTH);
   // I/O bytes and high RAM share one page store indexed by the low address byte
   localparam int HPAGE_DEPTH = 256;
   localparam int HPAGE_AW    = $clog2(HPAGE_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      TGT_LOCAL  = 3'd0,
      TGT_CART   = 3'd1,
      TGT_VRAM   = 3'd2,
      TGT_OAM    = 3'd3,
      TGT_JOYPAD = 3'd4,
      TGT_TIMER  = 3'd5,
      TGT_AUDIO  = 3'd6,
      TGT_LCD    = 3'd7
   } mmbd_target_type;

   typedef enum logic [2:0] {
      LOC_NONE,
      LOC_WRAM,
      LOC_HPAGE,
      LOC_IF,
      LOC_IE
   } mmbd_loc_type;

   typedef struct packed {
      mmbd_target_type target;
      logic            is_write;
      mmbd_loc_type    loc;
      logic [15:0]     address;
      logic [7:0]      data;
   } mmbd_op_type;

   typedef struct packed {
      logic can_push;
      logic can_pop;
   } mmbd_q_stat_type;

   typedef struct packed {
      logic init_done;
   } mmbd_back_stat_type;

endpackage

>>> hdl/mmbd_if.sv
interface mmbd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source(output valid, req_type, address, write_data, input ready);
   modport sink(input valid, req_type, address, write_data, output ready);
endinterface

interface mmbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic [7:0]  read_data;
   logic        forward_write;
   logic [15:0] forward_address;
   logic [7:0]  forward_data;

   modport source(output valid, target, read_data, forward_write, forward_address,
                  forward_data, input ready);
   modport sink(input valid, target, read_data, forward_write, forward_address,
                forward_data, output ready);
endinterface

>>> hdl/memory_map_bus_decoder_core.sv
// Channel  Direction  Interface           Payload
// req_bus  in         mmbd_req_if.sink    req_type, address, write_data
// rsp_bus  out        mmbd_rsp_if.source  target, read_data, forward_write,
//                                         forward_address, forward_data
//
// Sustained rate is one transaction per cycle while rsp stays ready. A transaction
// accepted on req is first written into the 2-entry queue, then loaded into the
// output register together with the memory read, once that register is free.
// After reset the work RAM is cleared one byte per cycle, all 8192 bytes, with req
// held not ready. Reset is synchronous and active high.
// The 2-entry queue lets the decode side keep taking transactions while rsp stalls.
module memory_map_bus_decoder_core (
   input logic        clock,
   input logic        reset,
   mmbd_req_if.sink   req_bus,
   mmbd_rsp_if.source rsp_bus
);

   mmbd_pkg::mmbd_op_type        push_op;
   mmbd_pkg::mmbd_op_type        head_op;
   mmbd_pkg::mmbd_q_stat_type    q_stat;
   mmbd_pkg::mmbd_back_stat_type back_stat;
   logic                        push;
   logic                        pop;

   mmbd_front u_front (
      .req_bus   (req_bus),
      .q_stat    (q_stat),
      .back_stat (back_stat),
      .push      (push),
      .push_op   (push_op)
   );

   mmbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .q_stat  (q_stat)
   );

   mmbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .q_stat    (q_stat),
      .pop       (pop),
      .back_stat (back_stat),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> hdl/mmbd_front.sv
module mmbd_front (
   mmbd_req_if.sink                    req_bus,
   input  mmbd_pkg::mmbd_q_stat_type    q_stat,
   input  mmbd_pkg::mmbd_back_stat_type back_stat,
   output logic                        push,
   output mmbd_pkg::mmbd_op_type        push_op
);

   logic [15:0] a;

   assign a             = req_bus.address;
   assign req_bus.ready = q_stat.can_push & back_stat.init_done;
   assign push          = req_bus.valid & req_bus.ready;

   always_comb begin
      push_op.is_write = req_bus.req_type;
      push_op.address  = a;
      push_op.data     = req_bus.write_data;
      push_op.target   = mmbd_pkg::TGT_LOCAL;
      push_op.loc      = mmbd_pkg::LOC_NONE;

      if (a < mmbd_pkg::ADDR_VRAM_BASE) begin
         push_op.target = mmbd_pkg::TGT_CART;
      end else if (a < mmbd_pkg::ADDR_CART_RAM_BASE) begin
         push_op.target = mmbd_pkg::TGT_VRAM;
      end else if (a < mmbd_pkg::ADDR_WRAM_BASE) begin
         push_op.target = mmbd_pkg::TGT_CART;
      end else if (a < mmbd_pkg::ADDR_OAM_BASE) begin
         // work RAM and its echo both index by the low bits
         push_op.loc = mmbd_pkg::LOC_WRAM;
      end else if (a < mmbd_pkg::ADDR_UNUSABLE_BASE) begin
         push_op.target = mmbd_pkg::TGT_OAM;
      end else if (a < mmbd_pkg::ADDR_IO_BASE) begin
         push_op.loc = mmbd_pkg::LOC_NONE;
      end else if (a < mmbd_pkg::ADDR_HRAM_BASE) begin
         if (a == mmbd_pkg::ADDR_JOYPAD) begin
            push_op.target = mmbd_pkg::TGT_JOYPAD;
         end else if (a >= mmbd_pkg::ADDR_TIMER_LO && a <= mmbd_pkg::ADDR_TIMER_HI) begin
            push_op.target = mmbd_pkg::TGT_TIMER;
         end else if (a >= mmbd_pkg::ADDR_AUDIO_LO && a <= mmbd_pkg::ADDR_AUDIO_HI) begin
            push_op.target = mmbd_pkg::TGT_AUDIO;
         end else if (a >= mmbd_pkg::ADDR_LCD_LO && a <= mmbd_pkg::ADDR_LCD_HI) begin
            push_op.target = mmbd_pkg::TGT_LCD;
         end else if (a == mmbd_pkg::ADDR_IF) begin
            push_op.loc = mmbd_pkg::LOC_IF;
         end else begin
            push_op.loc = mmbd_pkg::LOC_HPAGE;
         end
      end else if (a == mmbd_pkg::ADDR_IE) begin
         push_op.loc = mmbd_pkg::LOC_IE;
      end else begin
         push_op.loc = mmbd_pkg::LOC_HPAGE;
      end

      // serial control bit 7 never sticks
      if (a == mmbd_pkg::ADDR_SERIAL_CTRL) begin
         push_op.data = req_bus.write_data & mmbd_pkg::SERIAL_CTRL_MASK;
      end
   end

endmodule

>>> hdl/mmbd_queue.sv
module mmbd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mmbd_pkg::mmbd_op_type     push_op,
   input  logic                     pop,
   output mmbd_pkg::mmbd_op_type     head_op,
   output mmbd_pkg::mmbd_q_stat_type q_stat
);

   mmbd_pkg::mmbd_op_type                 entry_ff [mmbd_pkg::QUEUE_DEPTH];
   logic [mmbd_pkg::QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mmbd_pkg::QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mmbd_pkg::QUEUE_CW-1:0]         count_ff, count_in;

   localparam logic [mmbd_pkg::QUEUE_AW-1:0] LAST_PTR =
      mmbd_pkg::QUEUE_AW'(mmbd_pkg::QUEUE_DEPTH - 1);
   localparam logic [mmbd_pkg::QUEUE_CW-1:0] FULL_COUNT =
      mmbd_pkg::QUEUE_CW'(mmbd_pkg::QUEUE_DEPTH);

   assign q_stat.can_push = (count_ff != FULL_COUNT);
   assign q_stat.can_pop  = (count_ff != '0);
   assign head_op         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL_COUNT) || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

>>> hdl/mmbd_back.sv
module mmbd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mmbd_pkg::mmbd_op_type        head_op,
   input  mmbd_pkg::mmbd_q_stat_type    q_stat,
   output logic                        pop,
   output mmbd_pkg::mmbd_back_stat_type back_stat,
   mmbd_rsp_if.source                  rsp_bus
);

   logic [7:0] wram [mmbd_pkg::WRAM_DEPTH];
   logic [7:0] hpage [mmbd_pkg::HPAGE_DEPTH];
   logic [mmbd_pkg::HPAGE_DEPTH-1:0] hpage_vld_ff;

   logic [mmbd_pkg::WRAM_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                          clr_done_ff, clr_done_in;
   logic                          out_vld_ff, out_vld_in;
   mmbd_pkg::mmbd_op_type          op_ff;
   logic [7:0]                    wram_q_ff;
   logic [7:0]                    hpage_q_ff;
   logic                          hpage_vld_q_ff;
   logic [7:0]                    if_ff, ie_ff;

   logic                          wram_we, wram_re, hpage_we, hpage_re;
   logic [mmbd_pkg::WRAM_AW-1:0]  wram_addr, head_wram_idx;
   logic [7:0]                    wram_wd;
   logic [mmbd_pkg::HPAGE_AW-1:0] head_hpage_idx;
   logic                          op_wr_local;
   logic                          fwd;
   logic [7:0]                    local_rd;

   localparam logic [mmbd_pkg::WRAM_AW-1:0] CLR_LAST =
      mmbd_pkg::WRAM_AW'(mmbd_pkg::WRAM_DEPTH - 1);

   assign pop = q_stat.can_pop & clr_done_ff & (~out_vld_ff | rsp_bus.ready);
   assign back_stat.init_done = clr_done_ff;

   assign head_wram_idx  = head_op.address[mmbd_pkg::WRAM_AW-1:0];
   assign head_hpage_idx = head_op.address[mmbd_pkg::HPAGE_AW-1:0];
   assign op_wr_local    = pop & head_op.is_write & (head_op.target == mmbd_pkg::TGT_LOCAL);

   assign wram_we   = ~clr_done_ff | (op_wr_local & (head_op.loc == mmbd_pkg::LOC_WRAM));
   assign wram_addr = clr_done_ff ? head_wram_idx : clr_cnt_ff;
   assign wram_wd   = clr_done_ff ? head_op.data : 8'h00;
   assign wram_re   = pop & ~head_op.is_write & (head_op.loc == mmbd_pkg::LOC_WRAM);
   assign hpage_we  = op_wr_local & (head_op.loc == mmbd_pkg::LOC_HPAGE);
   assign hpage_re  = pop & ~head_op.is_write & (head_op.loc == mmbd_pkg::LOC_HPAGE);

   // power-up clear of work RAM, one byte per cycle, and output valid tracking
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_LAST) begin
            clr_done_in = 1'b1;
         end
      end
      out_vld_in = out_vld_ff;
      if (pop) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         clr_done_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
         hpage_vld_ff <= '0;
         if_ff        <= mmbd_pkg::IF_RESET;
         ie_ff        <= mmbd_pkg::IE_RESET;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_done_ff <= clr_done_in;
         out_vld_ff  <= out_vld_in;
         if (hpage_we) begin
            hpage_vld_ff[head_hpage_idx] <= 1'b1;
         end
         if (op_wr_local && head_op.loc == mmbd_pkg::LOC_IF) begin
            if_ff <= head_op.data;
         end
         if (op_wr_local && head_op.loc == mmbd_pkg::LOC_IE) begin
            ie_ff <= head_op.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head_op;
      end
      if (hpage_re) begin
         hpage_vld_q_ff <= hpage_vld_ff[head_hpage_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wram_we) begin
         wram[wram_addr] <= wram_wd;
      end
      if (wram_re) begin
         wram_q_ff <= wram[head_wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (hpage_we) begin
         hpage[head_hpage_idx] <= head_op.data;
      end
      if (hpage_re) begin
         hpage_q_ff <= hpage[head_hpage_idx];
      end
   end

   always_comb begin
      unique case (op_ff.loc)
         mmbd_pkg::LOC_WRAM:  local_rd = wram_q_ff;
         mmbd_pkg::LOC_HPAGE: local_rd = hpage_vld_q_ff ? hpage_q_ff : 8'h00;
         mmbd_pkg::LOC_IF:    local_rd = if_ff | mmbd_pkg::IF_READ_SET;
         mmbd_pkg::LOC_IE:    local_rd = ie_ff;
         default:             local_rd = mmbd_pkg::UNUSABLE_READ;
      endcase
   end

   assign fwd                     = (op_ff.target != mmbd_pkg::TGT_LOCAL);
   assign rsp_bus.valid           = out_vld_ff;
   assign rsp_bus.target          = op_ff.target;
   assign rsp_bus.forward_write   = fwd & op_ff.is_write;
   assign rsp_bus.forward_address = fwd ? op_ff.address : 16'h0000;
   assign rsp_bus.forward_data    = (fwd && op_ff.is_write) ? op_ff.data : 8'h00;
   assign rsp_bus.read_data       = (!fwd && !op_ff.is_write) ? local_rd : 8'h00;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      !clr_done_ff |-> !pop && !out_vld_ff)
      else $error("transaction served during work RAM clear");

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_vld_ff)
      else $error("popped transaction lost");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_bus.ready |-> !pop)
      else $error("pop while output stalled");

endmodule

>>> verif/memory_map_bus_decoder_core_test.sv
module memory_map_bus_decoder_core_test;

   localparam logic        ACCESS_READ    = 1'b0;
   localparam logic        ACCESS_WRITE   = 1'b1;
   localparam logic [15:0] ADDR_ECHO_BASE = 16'hE000;
   localparam logic [15:0] ADDR_ECHO_END  = 16'hFE00;
   localparam int          RANDOM_ACCESSES = 850;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          SETTLE_CYCLES   = 10;

   typedef struct {
      logic        is_write;
      logic [15:0] address;
      logic [7:0]  data;
      bit          drain_first;
   } bus_access_type;

   typedef struct {
      mmbd_pkg::mmbd_target_type target;
      logic [7:0]                read_data;
      logic                      fwd_write;
      logic [15:0]               fwd_address;
      logic [7:0]                fwd_data;
   } bus_response_type;

   typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_PERIODIC} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mmbd_req_if req_bus();
   mmbd_rsp_if rsp_bus();

   memory_map_bus_decoder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // local stores as the decoder should hold them
   logic [7:0] wram_model [mmbd_pkg::WRAM_DEPTH];
   logic [7:0] hram_model [127];
   logic [7:0] io_model [128];
   logic [7:0] ie_model;
   logic [7:0] if_model;

   bus_access_type   pending_accesses[$];
   bus_response_type predicted_responses[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  total_accesses = 0;
   int  accepted_count = 0;
   int  read_count = 0;
   int  write_count = 0;
   int  long_stalls = 0;
   int  target_hits [8];
   bit  req_taken = 1'b0;

   // sender burst state
   int  burst_left = 0;
   int  gap_left = 0;

   // receiver state
   ready_mode_type ready_mode = READY_ALWAYS;
   int  mode_left = 0;
   int  hold_left = 0;
   int  next_hold_at = 120;
   int  pattern_phase = 0;

   task automatic report_failure(input string msg);
      error_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic add_access(input logic w, input logic [15:0] a, input logic [7:0] d,
                             input bit drain);
      bus_access_type acc;
      acc.is_write    = w;
      acc.address     = a;
      acc.data        = d;
      acc.drain_first = drain;
      pending_accesses.push_back(acc);
   endtask

   // Decode one bus transaction and apply it to the local stores.
   function automatic bus_response_type decode_access(input bus_access_type acc);
      bus_response_type res;
      logic [15:0]      a;
      a = acc.address;
      res.read_data   = 8'h00;
      res.fwd_write   = 1'b0;
      res.fwd_address = 16'h0000;
      res.fwd_data    = 8'h00;

      if (a < mmbd_pkg::ADDR_VRAM_BASE) begin
         res.target = mmbd_pkg::TGT_CART;
      end else if (a < mmbd_pkg::ADDR_CART_RAM_BASE) begin
         res.target = mmbd_pkg::TGT_VRAM;
      end else if (a < mmbd_pkg::ADDR_WRAM_BASE) begin
         res.target = mmbd_pkg::TGT_CART;
      end else if (a < mmbd_pkg::ADDR_OAM_BASE) begin
         res.target = mmbd_pkg::TGT_LOCAL;
      end else if (a < mmbd_pkg::ADDR_UNUSABLE_BASE) begin
         res.target = mmbd_pkg::TGT_OAM;
      end else if (a < mmbd_pkg::ADDR_IO_BASE) begin
         res.target = mmbd_pkg::TGT_LOCAL;
      end else if (a == mmbd_pkg::ADDR_JOYPAD) begin
         res.target = mmbd_pkg::TGT_JOYPAD;
      end else if (a >= mmbd_pkg::ADDR_TIMER_LO && a <= mmbd_pkg::ADDR_TIMER_HI) begin
         res.target = mmbd_pkg::TGT_TIMER;
      end else if (a >= mmbd_pkg::ADDR_AUDIO_LO && a <= mmbd_pkg::ADDR_AUDIO_HI) begin
         res.target = mmbd_pkg::TGT_AUDIO;
      end else if (a >= mmbd_pkg::ADDR_LCD_LO && a <= mmbd_pkg::ADDR_LCD_HI) begin
         res.target = mmbd_pkg::TGT_LCD;
      end else begin
         res.target = mmbd_pkg::TGT_LOCAL;
      end

      if (res.target != mmbd_pkg::TGT_LOCAL) begin
         res.fwd_write   = acc.is_write;
         res.fwd_address = a;
         res.fwd_data    = (acc.is_write == ACCESS_WRITE) ? acc.data : 8'h00;
         return res;
      end

      // work RAM and its echo both index by the low 13 address bits
      if (acc.is_write == ACCESS_WRITE) begin
         if (a >= mmbd_pkg::ADDR_WRAM_BASE && a < mmbd_pkg::ADDR_OAM_BASE) begin
            wram_model[a[12:0]] = acc.data;
         end else if (a == mmbd_pkg::ADDR_IF) begin
            if_model = acc.data;
         end else if (a == mmbd_pkg::ADDR_SERIAL_CTRL) begin
            io_model[a[6:0]] = acc.data & mmbd_pkg::SERIAL_CTRL_MASK;
         end else if (a >= mmbd_pkg::ADDR_IO_BASE && a < mmbd_pkg::ADDR_HRAM_BASE) begin
            io_model[a[6:0]] = acc.data;
         end else if (a >= mmbd_pkg::ADDR_HRAM_BASE && a < mmbd_pkg::ADDR_IE) begin
            hram_model[a[6:0]] = acc.data;
         end else if (a == mmbd_pkg::ADDR_IE) begin
            ie_model = acc.data;
         end
         // unusable region: dropped
      end else begin
         if (a >= mmbd_pkg::ADDR_WRAM_BASE && a < mmbd_pkg::ADDR_OAM_BASE) begin
            res.read_data = wram_model[a[12:0]];
         end else if (a == mmbd_pkg::ADDR_IF) begin
            res.read_data = if_model | mmbd_pkg::IF_READ_SET;
         end else if (a >= mmbd_pkg::ADDR_IO_BASE && a < mmbd_pkg::ADDR_HRAM_BASE) begin
            res.read_data = io_model[a[6:0]];
         end else if (a >= mmbd_pkg::ADDR_HRAM_BASE && a < mmbd_pkg::ADDR_IE) begin
            res.read_data = hram_model[a[6:0]];
         end else if (a == mmbd_pkg::ADDR_IE) begin
            res.read_data = ie_model;
         end else begin
            res.read_data = mmbd_pkg::UNUSABLE_READ;
         end
      end
      return res;
   endfunction

   // Sender: bursts of transactions separated by random gaps.
   always @(negedge clock) begin
      bus_access_type acc;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_accesses.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (pending_accesses[0].drain_first && predicted_responses.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            acc = pending_accesses.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.req_type   <= acc.is_write;
            req_bus.address    <= acc.address;
            req_bus.write_data <= acc.data;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Receiver: stall pattern changes every so often, with a few long hold-offs.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (accepted_count >= next_hold_at) begin
         next_hold_at = next_hold_at + 330;
         hold_left    = $urandom_range(40, 90);
         long_stalls++;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left  = $urandom_range(16, 120);
            ready_mode = ready_mode_type'($urandom_range(0, 3));
         end
         mode_left--;
         pattern_phase++;
         case (ready_mode)
            READY_ALWAYS:   rsp_bus.ready <= 1'b1;
            READY_HALF:     rsp_bus.ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY:   rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: rsp_bus.ready <= (pattern_phase % 4 != 3);
         endcase
      end
   end

   // Monitor: check responses, then record newly accepted transactions.
   always @(posedge clock) begin
      bus_response_type want;
      bus_access_type   acc;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end else begin
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_responses.size() == 0) begin
               report_failure($sformatf("unexpected response target %0d addr 0x%04h",
                                        rsp_bus.target, rsp_bus.forward_address));
            end else begin
               want = predicted_responses.pop_front();
               target_hits[rsp_bus.target]++;
               if (rsp_bus.target !== want.target)
                  report_failure($sformatf("target got %0d expected %0d",
                                           rsp_bus.target, want.target));
               if (rsp_bus.read_data !== want.read_data)
                  report_failure($sformatf("read_data got 0x%02h expected 0x%02h",
                                           rsp_bus.read_data, want.read_data));
               if (rsp_bus.forward_write !== want.fwd_write)
                  report_failure($sformatf("forward_write got %0b expected %0b",
                                           rsp_bus.forward_write, want.fwd_write));
               if (rsp_bus.forward_address !== want.fwd_address)
                  report_failure($sformatf("forward_address got 0x%04h expected 0x%04h",
                                           rsp_bus.forward_address, want.fwd_address));
               if (rsp_bus.forward_data !== want.fwd_data)
                  report_failure($sformatf("forward_data got 0x%02h expected 0x%02h",
                                           rsp_bus.forward_data, want.fwd_data));
            end
         end
         req_taken = !reset && req_bus.valid && req_bus.ready;
         if (req_taken) begin
            acc.is_write    = req_bus.req_type;
            acc.address     = req_bus.address;
            acc.data        = req_bus.write_data;
            acc.drain_first = 1'b0;
            predicted_responses.push_back(decode_access(acc));
            accepted_count++;
            if (acc.is_write == ACCESS_WRITE) write_count++;
            else                              read_count++;
         end
      end
   end

   initial begin
      int          n;
      int          pick;
      bit          drained_mid;
      logic [15:0] a;
      logic [15:0] b;
      logic [7:0]  d;

      req_bus.valid      = 1'b0;
      req_bus.req_type   = ACCESS_READ;
      req_bus.address    = 16'h0000;
      req_bus.write_data = 8'h00;
      rsp_bus.ready      = 1'b0;

      foreach (wram_model[i]) wram_model[i] = 8'h00;
      foreach (hram_model[i]) hram_model[i] = 8'h00;
      foreach (io_model[i])   io_model[i]   = 8'h00;
      ie_model = mmbd_pkg::IE_RESET;
      if_model = mmbd_pkg::IF_RESET;

      // directed: reset values, echo aliasing, special registers, range edges
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_IF,          8'h00, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_IE,          8'h00, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_WRAM_BASE,   8'hA5, 1'b0);
      add_access(ACCESS_READ,  ADDR_ECHO_BASE,             8'hFF, 1'b0);
      add_access(ACCESS_WRITE, 16'hFDFF,                   8'h5A, 1'b0);
      add_access(ACCESS_READ,  16'hDDFF,                   8'h00, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_SERIAL_CTRL, 8'hFF, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_SERIAL_CTRL, 8'h00, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_IF,          8'h00, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_IF,          8'h00, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_UNUSABLE_BASE, 8'h00, 1'b0);
      add_access(ACCESS_WRITE, 16'hFEFF,                   8'h12, 1'b0);
      add_access(ACCESS_READ,  16'hFEFF,                   8'h00, 1'b0);
      add_access(ACCESS_READ,  16'hFFFE,                   8'h00, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_IE,          8'hFF, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_IE,          8'h00, 1'b0);
      add_access(ACCESS_READ,  16'h0000,                   8'hFF, 1'b0);
      add_access(ACCESS_WRITE, 16'h7FFF,                   8'hFF, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_VRAM_BASE,   8'h00, 1'b0);
      add_access(ACCESS_WRITE, 16'hBFFF,                   8'h3C, 1'b0);
      add_access(ACCESS_WRITE, 16'hFE9F,                   8'h81, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_JOYPAD,      8'h00, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_TIMER_HI,    8'h07, 1'b0);
      add_access(ACCESS_WRITE, mmbd_pkg::ADDR_AUDIO_HI,    8'hC3, 1'b0);
      add_access(ACCESS_READ,  mmbd_pkg::ADDR_LCD_HI,      8'h00, 1'b0);
      add_access(ACCESS_READ,  16'hFF4C,                   8'h00, 1'b0);

      // random part, sender waits for an empty pipe before starting it and once more midway
      n = 0;
      drained_mid = 1'b0;
      while (n < RANDOM_ACCESSES) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            if ($urandom_range(0, 1))
               a = mmbd_pkg::ADDR_WRAM_BASE + 16'($urandom_range(0, 63));
            else
               a = 16'($urandom_range(mmbd_pkg::ADDR_WRAM_BASE, ADDR_ECHO_END - 1));
         end else if (pick < 45) begin
            a = 16'($urandom_range(mmbd_pkg::ADDR_IO_BASE, 16'hFFFF));
         end else if (pick < 52) begin
            a = 16'($urandom_range(mmbd_pkg::ADDR_UNUSABLE_BASE, mmbd_pkg::ADDR_IO_BASE - 1));
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0:       a = 16'($urandom_range(0, mmbd_pkg::ADDR_WRAM_BASE - 1));
               1:       a = 16'($urandom_range(mmbd_pkg::ADDR_OAM_BASE,
                                               mmbd_pkg::ADDR_UNUSABLE_BASE - 1));
               default: a = 16'($urandom_range(mmbd_pkg::ADDR_IO_BASE,
                                               mmbd_pkg::ADDR_LCD_HI));
            endcase
         end else begin
            a = 16'($urandom_range(0, 16'hFFFF));
         end
         d = 8'($urandom_range(0, 255));

         if ($urandom_range(0, 99) < 35) begin
            // write then read back, sometimes through the echo alias
            b = a;
            if ($urandom_range(0, 1)) begin
               if (a >= mmbd_pkg::ADDR_WRAM_BASE && a < mmbd_pkg::ADDR_WRAM_BASE + 16'h1E00)
                  b = a + 16'h2000;
               else if (a >= ADDR_ECHO_BASE && a < ADDR_ECHO_END)
                  b = a - 16'h2000;
            end
            add_access(ACCESS_WRITE, a, d, n == 0 || (n >= 425 && !drained_mid));
            add_access(ACCESS_READ, b, 8'($urandom_range(0, 255)), 1'b0);
            n += 2;
         end else begin
            add_access(1'($urandom_range(0, 1)), a, d, n == 0 || (n >= 425 && !drained_mid));
            n++;
         end
         if (n >= 425) drained_mid = 1'b1;
      end
      total_accesses = pending_accesses.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (accepted_count < total_accesses || predicted_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      foreach (predicted_responses[i])
         report_failure($sformatf("response never arrived: target %0d addr 0x%04h",
                                  predicted_responses[i].target,
                                  predicted_responses[i].fwd_address));

      $display("Covered %0d transactions (%0d reads, %0d writes) in %0d cycles, %0d long stalls",
               accepted_count, read_count, write_count, cycle_count, long_stalls);
      $write("Units hit: local %0d cart %0d vram %0d oam %0d ",
             target_hits[mmbd_pkg::TGT_LOCAL], target_hits[mmbd_pkg::TGT_CART],
             target_hits[mmbd_pkg::TGT_VRAM], target_hits[mmbd_pkg::TGT_OAM]);
      $display("joypad %0d timer %0d audio %0d lcd %0d",
               target_hits[mmbd_pkg::TGT_JOYPAD], target_hits[mmbd_pkg::TGT_TIMER],
               target_hits[mmbd_pkg::TGT_AUDIO], target_hits[mmbd_pkg::TGT_LCD]);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
